/* rtl/cdir_pkg.sv */
package cdir_pkg;

    // Default geometry of the directory.
    localparam int SETS_DEF       = 64;
    localparam int LINE_BYTES_DEF = 32;
    localparam int ADDR_WIDTH_DEF = 32;

    // Width of the running hit and miss counts, and their saturation value.
    localparam int                CNT_W   = 32;
    localparam logic [CNT_W-1:0]  CNT_MAX = '1;

    // Widest tag that the directory keeps.
    localparam int TAG_W_MAX = 32;

    // Field widths come from the floor of the base-2 logarithm.
    function automatic int floor_log2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

    // Per-set status: valid flops and the recency bit kept in the tag row.
    typedef struct packed {
        logic [1:0] valid;
        logic       recent;
    } dir_rd_t;

    // Update of the per-set status and counters when a lookup retires.
    typedef struct packed {
        logic en;
        logic miss;
        logic way;
    } dir_upd_t;

endpackage

/* rtl/cdir_ram.sv */
module cdir_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/cdir_lookup.sv */
module cdir_lookup import cdir_pkg::*; #(
    parameter int TAG_W = 21
) (
    input  logic [TAG_W-1:0]   tag,
    input  logic [2*TAG_W-1:0] row,
    input  dir_rd_t            rd,
    output logic               miss,
    output logic               way,
    output logic               ev_valid,
    output logic [TAG_W-1:0]   ev_tag,
    output logic [2*TAG_W-1:0] new_row
);

    logic [TAG_W-1:0] tag0;
    logic [TAG_W-1:0] tag1;
    logic             hit0;
    logic             hit1;
    logic [TAG_W-1:0] victim;

    always_comb
    begin
        tag0 = row[TAG_W-1:0];
        tag1 = row[2*TAG_W-1:TAG_W];
        hit0 = rd.valid[0] && (tag0 == tag);
        hit1 = rd.valid[1] && (tag1 == tag);
        miss = !hit0 && !hit1;
        // On a miss the way that was not used last is refilled.
        way  = miss ? !rd.recent : hit1;
        victim   = way ? tag1 : tag0;
        ev_valid = miss && rd.valid[way];
        ev_tag   = ev_valid ? victim : '0;
        if (!miss)
        begin
            new_row = row;
        end
        else if (way)
        begin
            new_row = {tag, tag0};
        end
        else
        begin
            new_row = {tag1, tag};
        end
    end

endmodule

/* rtl/cdir_state.sv */
module cdir_state import cdir_pkg::*; #(
    parameter int SET_BITS = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SET_BITS-1:0] set_idx,
    input  logic                row_recent,
    input  dir_upd_t            upd,
    output dir_rd_t             rd,
    output logic [CNT_W-1:0]    hits_next,
    output logic [CNT_W-1:0]    misses_next
);

    localparam int NUM_SETS = 1 << SET_BITS;

    logic [NUM_SETS-1:0] valid0_reg;
    logic [NUM_SETS-1:0] valid1_reg;
    logic [CNT_W-1:0]    hits_reg;
    logic [CNT_W-1:0]    misses_reg;

    always_comb
    begin
        rd.valid  = {valid1_reg[set_idx], valid0_reg[set_idx]};
        // A set that holds no valid line has never been touched, so way 1
        // still counts as the most recent one there.
        rd.recent = (valid0_reg[set_idx] || valid1_reg[set_idx]) ? row_recent : 1'b1;

        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (upd.en && !upd.miss && (hits_reg != CNT_MAX))
        begin
            hits_next = hits_reg + CNT_W'(1);
        end
        if (upd.en && upd.miss && (misses_reg != CNT_MAX))
        begin
            misses_next = misses_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= '0;
            valid1_reg <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
        end
        else if (upd.en)
        begin
            if (upd.miss && !upd.way)
            begin
                valid0_reg[set_idx] <= 1'b1;
            end
            if (upd.miss && upd.way)
            begin
                valid1_reg[set_idx] <= 1'b1;
            end
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
        end
    end

endmodule

/* rtl/two_way_cache_tag_directory_lru_unit.sv */
// Tag directory of a two-way set-associative cache with LRU replacement.
// The input channel (in_valid, in_ready, address) carries one byte address
// per transaction. The output channel (out_valid, out_ready and the result
// fields) returns one transaction per address, in order: hit or miss, the
// way hit or filled, the address split into set, offset and tag, the tag of
// an evicted valid line, and the saturating hit and miss counts.
// A transaction is registered into the lookup stage when accepted, looked up
// there, and its result is then registered in the result register that
// drives out_valid. Throughput is one transaction per cycle while the
// receiver does not stall: the tag row, which also holds the most recent
// way of its set, is read as the address is accepted and rewritten when the
// lookup retires, with a one-row bypass for back-to-back references to the
// same set.
// Reset clears all valid bits and zeroes both counts, all at once. A set
// with no valid line reads way 1 as most recent, so the tag RAM needs no
// clearing pass since its contents are only used behind a valid bit.
// When the receiver stalls, the result register holds, the lookup stage
// holds one more transaction, and in_ready drops once both are full.
module two_way_cache_tag_directory_lru_unit import cdir_pkg::*; #(
    parameter int  SETS       = SETS_DEF,
    parameter int  LINE_BYTES = LINE_BYTES_DEF,
    parameter int  ADDR_WIDTH = ADDR_WIDTH_DEF,
    localparam int OFF_BITS   = floor_log2(LINE_BYTES),
    localparam int SET_BITS   = floor_log2(SETS),
    localparam int RAW_TAG    = ADDR_WIDTH - OFF_BITS - SET_BITS,
    localparam int TAG_W      = (RAW_TAG < 1) ? 1 :
                                ((RAW_TAG > TAG_W_MAX) ? TAG_W_MAX : RAW_TAG)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADDR_WIDTH-1:0] address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  miss,
    output logic                  way,
    output logic [SET_BITS-1:0]   set_index,
    output logic [OFF_BITS-1:0]   line_offset,
    output logic [TAG_W-1:0]      line_tag,
    output logic                  evicted_valid,
    output logic [TAG_W-1:0]      evicted_tag,
    output logic [CNT_W-1:0]      hits_so_far,
    output logic [CNT_W-1:0]      misses_so_far
);

    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int EXT_W    = ADDR_WIDTH + OFF_BITS + SET_BITS + TAG_W;
    localparam int TAGS_W   = 2 * TAG_W;
    // A row holds both tags and, on top, the most recent way of the set.
    localparam int ROW_W    = TAGS_W + 1;

    // Address split of the incoming transaction.
    logic [EXT_W-1:0]    addr_ext;
    logic [OFF_BITS-1:0] in_off;
    logic [SET_BITS-1:0] in_set;
    logic [TAG_W-1:0]    in_tag;
    logic                in_accept;

    // Lookup stage.
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [OFF_BITS-1:0] s1_off_reg;
    logic [SET_BITS-1:0] s1_set_reg;
    logic [TAG_W-1:0]    s1_tag_reg;
    logic                fwd_sel_reg;
    logic                fwd_sel_next;
    logic [ROW_W-1:0]    fwd_row_reg;
    logic [ROW_W-1:0]    ram_rdata;
    logic [ROW_W-1:0]    s1_row;

    // Lookup results.
    dir_rd_t             dir_rd;
    dir_upd_t            dir_upd;
    logic                lk_miss;
    logic                lk_way;
    logic                lk_ev_valid;
    logic [TAG_W-1:0]    lk_ev_tag;
    logic [TAGS_W-1:0]   lk_new_tags;
    logic [ROW_W-1:0]    wr_row;
    logic [CNT_W-1:0]    hits_next;
    logic [CNT_W-1:0]    misses_next;
    logic                res_load;
    logic                wr_en;

    // Result register.
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                miss_reg;
    logic                way_reg;
    logic [SET_BITS-1:0] set_reg;
    logic [OFF_BITS-1:0] off_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic                ev_valid_reg;
    logic [TAG_W-1:0]    ev_tag_reg;
    logic [CNT_W-1:0]    hits_reg;
    logic [CNT_W-1:0]    misses_reg;

    // Address bits above ADDR_WIDTH read as zero, which also covers narrow
    // configurations where the tag field would be empty.
    always_comb
    begin
        addr_ext = EXT_W'(address);
        in_off   = addr_ext[OFF_BITS-1:0];
        in_set   = addr_ext[OFF_BITS +: SET_BITS];
        if (RAW_TAG > 0)
        begin
            in_tag = addr_ext[OFF_BITS+SET_BITS +: TAG_W];
        end
        else
        begin
            in_tag = '0;
        end
    end

    // The lookup stage retires into the result register when that register
    // is empty or being drained; a new address enters behind it. Every
    // retiring lookup rewrites its row, whether or not the recency bit changes.
    assign res_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || res_load;
    assign in_accept = in_valid && in_ready;
    assign wr_en     = res_load;
    assign wr_row    = {lk_way, lk_new_tags};

    // A row written at the same edge as the read of a new address is not
    // seen by that read, so the written row is kept and used instead.
    assign fwd_sel_next = wr_en && (s1_set_reg == in_set);
    assign s1_row       = fwd_sel_reg ? fwd_row_reg : ram_rdata;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (res_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    cdir_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_set_reg),
        .wdata (wr_row),
        .re    (in_accept),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    cdir_state #(
        .SET_BITS (SET_BITS)
    ) u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .set_idx     (s1_set_reg),
        .row_recent  (s1_row[ROW_W-1]),
        .upd         (dir_upd),
        .rd          (dir_rd),
        .hits_next   (hits_next),
        .misses_next (misses_next)
    );

    cdir_lookup #(
        .TAG_W (TAG_W)
    ) u_lookup (
        .tag      (s1_tag_reg),
        .row      (s1_row[TAGS_W-1:0]),
        .rd       (dir_rd),
        .miss     (lk_miss),
        .way      (lk_way),
        .ev_valid (lk_ev_valid),
        .ev_tag   (lk_ev_tag),
        .new_row  (lk_new_tags)
    );

    always_comb
    begin
        dir_upd.en   = res_load;
        dir_upd.miss = lk_miss;
        dir_upd.way  = lk_way;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                fwd_sel_reg <= fwd_sel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_off_reg  <= in_off;
            s1_set_reg  <= in_set;
            s1_tag_reg  <= in_tag;
            fwd_row_reg <= wr_row;
        end
        if (res_load)
        begin
            miss_reg     <= lk_miss;
            way_reg      <= lk_way;
            set_reg      <= s1_set_reg;
            off_reg      <= s1_off_reg;
            tag_reg      <= s1_tag_reg;
            ev_valid_reg <= lk_ev_valid;
            ev_tag_reg   <= lk_ev_tag;
            hits_reg     <= hits_next;
            misses_reg   <= misses_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign miss          = miss_reg;
    assign way           = way_reg;
    assign set_index     = set_reg;
    assign line_offset   = off_reg;
    assign line_tag      = tag_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_tag   = ev_tag_reg;
    assign hits_so_far   = hits_reg;
    assign misses_so_far = misses_reg;

`ifndef SYNTHESIS
    // A hit never reports an eviction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !miss) |-> (!evicted_valid && (evicted_tag == '0)))
    else $error("hit result carries an eviction");

    // A lookup waiting on a stalled result register is not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !res_load) |=> s1_valid_reg)
    else $error("lookup stage lost a transaction");

    // A lookup followed at once by the same line must hit through the bypass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && in_accept && (in_set == s1_set_reg) && (in_tag == s1_tag_reg))
        |=> (s1_valid_reg && !lk_miss))
    else $error("back-to-back reference missed a line just filled");

    // Each retired lookup advances exactly one of the two counts unless it
    // is saturated.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> ((hits_next == hits_so_far && out_valid) || !out_valid ||
                      (misses_next == misses_so_far) || (hits_next == CNT_MAX) ||
                      (misses_next == CNT_MAX)))
    else $error("both counts advanced for one lookup");
`endif

endmodule
